// ----- src/snz_pkg.sv -----
// Package for the 2D simplex noise block generator.
// Holds request and pipeline types, fixed-point constants and hash helpers.
// No dependencies.
package snz_pkg;

    typedef struct packed {
        logic signed [33:0] x_base;
        logic signed [33:0] y_base;
        logic signed [32:0] x_span;
        logic signed [32:0] y_span;
    } req_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] column;
        logic [1:0] row;
        logic       last;
    } meta_t;

    localparam logic signed [63:0] F2_Q24    = 64'sd6140887;
    localparam logic [63:0]        G2_Q32_U  = 64'd907633386;
    localparam logic signed [35:0] G2_Q32    = 36'sd907633386;
    localparam logic signed [35:0] ONE_Q32   = 36'sd4294967296;
    localparam logic signed [37:0] HALF_Q28  = 38'sd134217728;
    localparam logic signed [63:0] SCALE_Q16 = 64'sd5928472;
    localparam logic signed [63:0] SUM_RND   = 64'sd16777216;
    localparam logic signed [15:0] OUT_MAX   = 16'sd32767;
    localparam logic signed [15:0] OUT_MIN   = -16'sd32768;

    localparam logic [31:0] HC0 = 32'h7ed55d16;
    localparam logic [31:0] HC1 = 32'hc761c23c;
    localparam logic [31:0] HC2 = 32'h165667b1;
    localparam logic [31:0] HC3 = 32'hd3a2646c;
    localparam logic [31:0] HC4 = 32'hfd7046c5;
    localparam logic [31:0] HC5 = 32'hb55a4f09;

    function automatic logic [31:0] mix_lo(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in;
        h = (h + HC0) + (h << 12);
        h = (h ^ HC1) ^ (h >> 19);
        h = (h + HC2) + (h << 5);
        return h;
    endfunction

    function automatic logic [31:0] mix_hi(input logic [31:0] h_in);
        logic [31:0] h;
        h = h_in;
        h = (h + HC3) ^ (h << 9);
        h = (h + HC4) + (h << 3);
        h = (h ^ HC5) ^ (h >> 16);
        return h;
    endfunction

    function automatic logic signed [31:0] round_q28(input logic signed [35:0] v);
        logic signed [35:0] s;
        s = (v + 36'sd8) >>> 4;
        return s[31:0];
    endfunction

    function automatic logic signed [33:0] grad_term(input logic signed [31:0] v,
                                                     input logic unit_sel,
                                                     input logic positive);
        logic signed [33:0] m;
        m = unit_sel ? (34'(v) <<< 1) : 34'(v);
        return positive ? m : -m;
    endfunction

endpackage

// ----- src/snz_fifo.sv -----
// Two-entry request queue between the front and the back of the noise block.
// Depends on snz_pkg for the request type.
module snz_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  snz_pkg::req_t push_data,
    input  logic          pop,
    output snz_pkg::req_t head,
    output logic          empty,
    output logic          full
);

    snz_pkg::req_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

endmodule

// ----- src/snz_front.sv -----
// Front of the noise block: accepts requests and turns them into base and span.
// Depends on snz_pkg for the request type.
module snz_front
(
    input  logic               start,
    input  logic               queue_full,
    input  logic signed [31:0] x_start,
    input  logic signed [31:0] y_start,
    input  logic signed [31:0] x_stop,
    input  logic signed [31:0] y_stop,
    output logic               busy,
    output logic               push,
    output snz_pkg::req_t      push_data
);

    always_comb
    begin
        busy              = queue_full;
        push              = start && !queue_full;
        push_data.x_base  = {x_start, 2'b00};
        push_data.y_base  = {y_start, 2'b00};
        push_data.x_span  = 33'(x_stop) - 33'(x_start);
        push_data.y_span  = 33'(y_stop) - 33'(y_start);
    end

endmodule

// ----- src/snz_back.sv -----
// Back of the noise block: walks the 4x4 grid and runs the sample pipeline.
// Depends on snz_pkg for types, constants and the hash helpers.
module snz_back
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int OUT_FRAC_BITS   = 15
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  snz_pkg::req_t      head,
    output logic               pop,
    output logic               strobe,
    output logic signed [15:0] noise_value,
    output logic [1:0]         column,
    output logic [1:0]         row,
    output logic               last
);

    localparam int CELL_SHIFT = COORD_FRAC_BITS + 26;
    localparam int OUT_SHIFT  = 48 - OUT_FRAC_BITS;
    localparam logic signed [63:0] OUT_RND = 64'sd1 <<< (OUT_SHIFT - 1);

    logic [3:0] sample_counter_reg, sample_counter_next;
    snz_pkg::meta_t meta_reg [1:14];
    snz_pkg::meta_t meta_next;

    logic signed [36:0] px_reg, py_reg, px2_reg, py2_reg;
    logic signed [63:0] sk_reg;
    logic [31:0] ci_reg, cj_reg, ci4_reg, ci5_reg;
    logic [31:0] fx_reg, fy_reg, fx4_reg, fy4_reg;
    logic [30:0] u_reg;
    logic [31:0] m0a_reg, m1a_reg, mj0_reg, mj1_reg;
    logic        i1_reg;
    logic signed [31:0] dx5_reg [3], dy5_reg [3], dx6_reg [3], dy6_reg [3];
    logic signed [31:0] dx7_reg [3], dy7_reg [3];
    logic [31:0] o_reg [3], h_reg [3];
    logic [63:0] sq_reg [3];
    logic [27:0] t_reg [3], t2_reg [3], t4_reg [3];
    logic signed [33:0] dot_reg [3], dot9_reg [3];
    logic signed [63:0] contrib_reg [3];
    logic signed [63:0] sum_reg, s32_reg, sp_reg;
    logic signed [15:0] noise_reg;

    logic signed [36:0] c_span_x, c_span_y;
    logic signed [63:0] xs, ys, xs_cell, ys_cell;
    logic [32:0] fsum;
    logic [63:0] uprod;
    logic signed [35:0] x0, y0, x1, y1, x2, y2;
    logic signed [63:0] o_full;

    function automatic logic signed [33:0] grad_dot(input logic [2:0] h,
                                                    input logic signed [31:0] dx,
                                                    input logic signed [31:0] dy);
        logic signed [33:0] a;
        logic signed [33:0] b;
        a = snz_pkg::grad_term(dx, !h[2], h[2] ? h[0] : h[1]);
        b = snz_pkg::grad_term(dy, h[2], h[2] ? h[1] : h[0]);
        return a + b;
    endfunction

    always_comb
    begin
        pop = !empty && (sample_counter_reg == 4'd15);
        sample_counter_next = empty ? sample_counter_reg : sample_counter_reg + 4'd1;
        meta_next.valid  = !empty;
        meta_next.column = sample_counter_reg[1:0];
        meta_next.row    = sample_counter_reg[3:2];
        meta_next.last   = (sample_counter_reg == 4'd15);
        c_span_x = (sample_counter_reg[0] ? 37'(head.x_span) : 37'sd0)
                 + (sample_counter_reg[1] ? (37'(head.x_span) <<< 1) : 37'sd0);
        c_span_y = (sample_counter_reg[2] ? 37'(head.y_span) : 37'sd0)
                 + (sample_counter_reg[3] ? (37'(head.y_span) <<< 1) : 37'sd0);
        xs = (64'(px2_reg) <<< 24) + sk_reg;
        ys = (64'(py2_reg) <<< 24) + sk_reg;
        xs_cell = xs >>> CELL_SHIFT;
        ys_cell = ys >>> CELL_SHIFT;
        fsum  = {1'b0, fx_reg} + {1'b0, fy_reg};
        uprod = 64'(fsum) * snz_pkg::G2_Q32_U;
        x0 = $signed({4'b0000, fx4_reg}) - $signed({5'b00000, u_reg});
        y0 = $signed({4'b0000, fy4_reg}) - $signed({5'b00000, u_reg});
        x1 = x0 - ((x0 > y0) ? snz_pkg::ONE_Q32 : 36'sd0) + snz_pkg::G2_Q32;
        y1 = y0 - ((x0 > y0) ? 36'sd0 : snz_pkg::ONE_Q32) + snz_pkg::G2_Q32;
        x2 = x0 - snz_pkg::ONE_Q32 + (snz_pkg::G2_Q32 <<< 1);
        y2 = y0 - snz_pkg::ONE_Q32 + (snz_pkg::G2_Q32 <<< 1);
        o_full = (sp_reg + OUT_RND) >>> OUT_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_counter_reg <= 4'd0;
            for (int s = 1; s <= 14; s++)
            begin
                meta_reg[s] <= '0;
            end
        end
        else
        begin
            sample_counter_reg <= sample_counter_next;
            meta_reg[1] <= meta_next;
            for (int s = 2; s <= 14; s++)
            begin
                meta_reg[s] <= meta_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= 37'(head.x_base) + c_span_x;
        py_reg  <= 37'(head.y_base) + c_span_y;
        sk_reg  <= (64'(px_reg) + 64'(py_reg)) * snz_pkg::F2_Q24;
        px2_reg <= px_reg;
        py2_reg <= py_reg;
        ci_reg  <= xs_cell[31:0];
        cj_reg  <= ys_cell[31:0];
        fx_reg  <= xs[COORD_FRAC_BITS+25 -: 32];
        fy_reg  <= ys[COORD_FRAC_BITS+25 -: 32];
        u_reg   <= uprod[62:32];
        fx4_reg <= fx_reg;
        fy4_reg <= fy_reg;
        ci4_reg <= ci_reg;
        m0a_reg <= snz_pkg::mix_lo(cj_reg);
        m1a_reg <= snz_pkg::mix_lo(cj_reg + 32'd1);
        i1_reg  <= (x0 > y0);
        ci5_reg <= ci4_reg;
        mj0_reg <= snz_pkg::mix_hi(m0a_reg);
        mj1_reg <= snz_pkg::mix_hi(m1a_reg);
        dx5_reg[0] <= snz_pkg::round_q28(x0);
        dy5_reg[0] <= snz_pkg::round_q28(y0);
        dx5_reg[1] <= snz_pkg::round_q28(x1);
        dy5_reg[1] <= snz_pkg::round_q28(y1);
        dx5_reg[2] <= snz_pkg::round_q28(x2);
        dy5_reg[2] <= snz_pkg::round_q28(y2);
        o_reg[0] <= snz_pkg::mix_lo(ci5_reg + mj0_reg);
        o_reg[1] <= snz_pkg::mix_lo(ci5_reg + 32'(i1_reg) + (i1_reg ? mj0_reg : mj1_reg));
        o_reg[2] <= snz_pkg::mix_lo(ci5_reg + 32'd1 + mj1_reg);
        for (int c = 0; c < 3; c++)
        begin
            sq_reg[c]  <= 64'(64'(dx5_reg[c]) * 64'(dx5_reg[c]))
                        + 64'(64'(dy5_reg[c]) * 64'(dy5_reg[c]));
            dx6_reg[c] <= dx5_reg[c];
            dy6_reg[c] <= dy5_reg[c];
            h_reg[c]   <= snz_pkg::mix_hi(o_reg[c]);
            t_reg[c]   <= ((snz_pkg::HALF_Q28 - $signed({2'b00, sq_reg[c][63:28]})) > 38'sd0)
                        ? 28'(snz_pkg::HALF_Q28 - $signed({2'b00, sq_reg[c][63:28]}))
                        : 28'd0;
            dx7_reg[c] <= dx6_reg[c];
            dy7_reg[c] <= dy6_reg[c];
            t2_reg[c]  <= 28'((56'(t_reg[c]) * 56'(t_reg[c])) >> 28);
            dot_reg[c] <= grad_dot(h_reg[c][2:0], dx7_reg[c], dy7_reg[c]);
            t4_reg[c]  <= 28'((56'(t2_reg[c]) * 56'(t2_reg[c])) >> 28);
            dot9_reg[c] <= dot_reg[c];
            contrib_reg[c] <= $signed({36'd0, t4_reg[c]}) * 64'(dot9_reg[c]);
        end
        sum_reg   <= contrib_reg[0] + contrib_reg[1] + contrib_reg[2];
        s32_reg   <= (sum_reg + snz_pkg::SUM_RND) >>> 25;
        sp_reg    <= s32_reg * snz_pkg::SCALE_Q16;
        noise_reg <= (o_full > 64'(snz_pkg::OUT_MAX)) ? snz_pkg::OUT_MAX
                   : (o_full < 64'(snz_pkg::OUT_MIN)) ? snz_pkg::OUT_MIN
                   : o_full[15:0];
    end

    assign strobe      = meta_reg[14].valid;
    assign column      = meta_reg[14].column;
    assign row         = meta_reg[14].row;
    assign last        = meta_reg[14].valid && meta_reg[14].last;
    assign noise_value = noise_reg;

endmodule

// ----- src/simplex_noise_2d_block.sv -----
// Top level of the 2D simplex noise block generator.
// Depends on snz_pkg, snz_front, snz_fifo and snz_back.
//
// A request carries start and exclusive stop coordinates in signed fixed point.
// It is accepted at a rising edge where start is high and busy is low. The
// block answers with 16 samples on a 4x4 grid, column fastest, each shown for
// exactly one cycle with strobe high; last marks the sixteenth sample.
// The back issues one sample per cycle while the queue holds a request, so the
// samples of requests that keep coming follow back to back, without waiting
// for earlier samples to leave the pipeline. A two-entry queue holds waiting
// requests; busy is high while it is full. The receiver cannot stall: results
// leave on strobe.
// Reset clears the queue, the sample counter and the pipeline valid flags, and
// nothing is emitted until the next request.
module simplex_noise_2d_block
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int OUT_FRAC_BITS   = 15
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_start,
    input  logic signed [31:0] y_start,
    input  logic signed [31:0] x_stop,
    input  logic signed [31:0] y_stop,
    output logic               strobe,
    output logic signed [15:0] noise_value,
    output logic [1:0]         column,
    output logic [1:0]         row,
    output logic               last
);

    logic          push;
    logic          pop;
    logic          empty;
    logic          full;
    snz_pkg::req_t push_data;
    snz_pkg::req_t head;

    snz_front u_front
    (
        .start      (start),
        .queue_full (full),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_stop     (x_stop),
        .y_stop     (y_stop),
        .busy       (busy),
        .push       (push),
        .push_data  (push_data)
    );

    snz_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    snz_back
    #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .OUT_FRAC_BITS   (OUT_FRAC_BITS)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .strobe      (strobe),
        .noise_value (noise_value),
        .column      (column),
        .row         (row),
        .last        (last)
    );

endmodule

// ----- src/snz_checker.sv -----
// Port-level checker for the 2D simplex noise block generator.
// Bound to simplex_noise_2d_block; no package dependencies.
module snz_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic [1:0] column,
    input logic [1:0] row,
    input logic       last
);

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> column == 2'd3 && row == 2'd3)
        else $error("Last sample is not at the final grid position.");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("Samples of one block are not back to back.");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && column != 2'd3 |=> column == $past(column) + 2'd1 && row == $past(row))
        else $error("Column did not advance.");

    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && column == 2'd3 && !last |=> column == 2'd0 && row == $past(row) + 2'd1)
        else $error("Row did not advance.");

endmodule

bind simplex_noise_2d_block snz_checker u_snz_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .column (column),
    .row    (row),
    .last   (last)
);
